// ===== src/bibe_pkg.sv =====
// Shared types and constants of the bit-image band encoder.
// No dependencies; imported by every module of the block but bibe_ram.
`timescale 1ns / 1ps

package bibe_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_BAND_ROWS = 24;

    // column word: row r of the band sits at bit WORD_BITS-1-r
    localparam int WORD_BITS = 24;
    localparam int ROW_BITS  = 5;
    localparam int IMG_W_BITS = 11;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [WORD_BITS-1:0] TOP_ROW_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_DENSITY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd1;

    localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH = 11'd576;

    localparam logic [7:0] MODE_HIGH    = 8'd33;
    localparam logic [7:0] MODE_NORMAL  = 8'd1;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [ROW_BITS-1:0] NORMAL_ROWS = 5'd8;

    // drain phases; the unused code behaves as PH_NEWLINE
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_DATA    = 2'd1;
    localparam logic [1:0] PH_NEWLINE = 2'd2;

    typedef struct packed {
        logic capture;   // input item taken this cycle
        logic commit;    // execute the held item and load the output register
    } t_cmd;

    typedef struct packed {
        logic out_full;  // output register holds an untaken result
    } t_status;

    typedef struct packed {
        logic       accepted;
        logic       misplaced_end;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       band_end;
        logic       image_end;
    } t_result;

endpackage

// ===== src/bibe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bibe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bibe_ctrl.sv =====
// Handshake controller: takes one item, then runs its execute step.
// Depends on bibe_pkg.
`timescale 1ns / 1ps

module bibe_ctrl
    import bibe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_m_ready,
    input  t_status i_status,
    output logic    o_s_ready,
    output t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // execute may go ahead once the output register is free or being emptied
    always_comb begin
        o_s_ready     = (r_state == S_IDLE);
        o_cmd.capture = o_s_ready && i_s_valid;
        o_cmd.commit  = (r_state == S_EXEC) && (!i_status.out_full || i_m_ready);
        n_state       = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/bibe_dp.sv =====
// Datapath: band store, fill and drain counters, config and output registers.
// Depends on bibe_pkg and bibe_ram.
`timescale 1ns / 1ps

module bibe_dp
    import bibe_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_BAND_ROWS = DEF_MAX_BAND_ROWS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_op,
    input  logic                    i_pixel,
    input  logic                    i_eoi,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [IMG_W_BITS-1:0]   i_cfg_data,
    input  logic                    i_m_ready,
    output t_result                 o_result
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
    localparam int SUMW = CMPW + 1;
    localparam logic [1:0] HI_BYTES = 2'((MAX_BAND_ROWS + 7) / 8);

    // configuration
    logic                  r_high_density;
    logic [IMG_W_BITS-1:0] r_image_width;

    // held item
    logic r_op;
    logic r_pix;
    logic r_eoi;

    // encoder state
    logic [CW-1:0]       r_column_index, n_column_index;
    logic [ROW_BITS-1:0] r_rows_filled,  n_rows_filled;
    logic                r_draining,     n_draining;
    logic [1:0]          r_phase,        n_phase;
    logic [CW-1:0]       r_drain_column, n_drain_column;
    logic [1:0]          r_drain_byte,   n_drain_byte;
    logic                r_final_band,   n_final_band;

    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] wr_word;
    logic                 wr_en;
    logic [CW-1:0]        rd_addr;

    logic [CMPW-1:0]     iw_ext;
    logic [CMPW-1:0]     eff_w;
    logic [15:0]         eff_w16;
    logic [SUMW-1:0]     col_plus;
    logic [SUMW-1:0]     dcol_plus;
    logic                last_col;
    logic [ROW_BITS-1:0] row_next;
    logic [ROW_BITS-1:0] band_rows;
    logic [1:0]          bytes_per_col;
    logic [1:0]          dbyte_plus;

    // read the column the item will touch, in the cycle it is taken
    assign rd_addr = i_op ? r_drain_column : r_column_index;

    bibe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_band_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_column_index),
        .i_wdata (wr_word),
        .i_re    (i_cmd.capture),
        .i_raddr (rd_addr),
        .o_rdata (rd_word)
    );

    always_comb begin
        // width clamped to 1..MAX_WIDTH
        iw_ext = CMPW'(r_image_width);
        if (iw_ext == '0) begin
            eff_w = CMPW'(1);
        end else if (iw_ext > CMPW'(MAX_WIDTH)) begin
            eff_w = CMPW'(MAX_WIDTH);
        end else begin
            eff_w = iw_ext;
        end
        eff_w16       = 16'(eff_w);
        col_plus      = SUMW'(r_column_index) + SUMW'(1);
        dcol_plus     = SUMW'(r_drain_column) + SUMW'(1);
        last_col      = (col_plus >= SUMW'(eff_w));
        row_next      = r_rows_filled + ROW_BITS'(1);
        band_rows     = r_high_density ? ROW_BITS'(MAX_BAND_ROWS) : NORMAL_ROWS;
        bytes_per_col = r_high_density ? HI_BYTES : 2'd1;
        dbyte_plus    = r_drain_byte + 2'd1;

        // first row of a band starts a fresh column word
        wr_word = (r_rows_filled == '0) ? '0 : rd_word;
        if (r_pix) begin
            wr_word = wr_word | (TOP_ROW_BIT >> r_rows_filled);
        end
        wr_en = i_cmd.commit && !r_op && !r_draining;

        n_column_index = r_column_index;
        n_rows_filled  = r_rows_filled;
        n_draining     = r_draining;
        n_phase        = r_phase;
        n_drain_column = r_drain_column;
        n_drain_byte   = r_drain_byte;
        n_final_band   = r_final_band;
        n_out          = '0;

        if (!r_op) begin
            if (!r_draining) begin
                n_out.accepted      = 1'b1;
                n_out.misplaced_end = r_eoi && !last_col;
                if (!last_col) begin
                    n_column_index = CW'(col_plus);
                end else begin
                    n_column_index = '0;
                    n_rows_filled  = row_next;
                    if (row_next >= band_rows || r_eoi) begin
                        n_rows_filled  = '0;
                        n_draining     = 1'b1;
                        n_final_band   = r_eoi;
                        n_phase        = PH_HEADER;
                        n_drain_column = '0;
                        n_drain_byte   = '0;
                    end
                end
            end
        end else if (r_draining) begin
            n_out.byte_valid = 1'b1;
            unique case (r_phase)
                PH_HEADER: begin
                    unique case (r_drain_byte)
                        2'd0:    n_out.data_byte = r_high_density ? MODE_HIGH : MODE_NORMAL;
                        2'd1:    n_out.data_byte = eff_w16[7:0];
                        default: n_out.data_byte = eff_w16[15:8];
                    endcase
                    if (r_drain_byte >= 2'd2) begin
                        n_drain_byte   = '0;
                        n_drain_column = '0;
                        n_phase        = PH_DATA;
                    end else begin
                        n_drain_byte = dbyte_plus;
                    end
                end
                PH_DATA: begin
                    unique case (r_drain_byte)
                        2'd0:    n_out.data_byte = rd_word[23:16];
                        2'd1:    n_out.data_byte = rd_word[15:8];
                        2'd2:    n_out.data_byte = rd_word[7:0];
                        default: n_out.data_byte = 8'd0;
                    endcase
                    n_drain_byte = dbyte_plus;
                    if (dbyte_plus >= bytes_per_col) begin
                        n_drain_byte = '0;
                        // column count is kept on the last column so it stays in range
                        if (dcol_plus >= SUMW'(eff_w)) begin
                            n_phase = PH_NEWLINE;
                        end else begin
                            n_drain_column = CW'(dcol_plus);
                        end
                    end
                end
                default: begin
                    n_out.data_byte = NEWLINE_BYTE;
                    n_out.band_end  = 1'b1;
                    n_out.image_end = r_final_band;
                    n_draining      = 1'b0;
                    n_final_band    = 1'b0;
                    n_phase         = PH_HEADER;
                    n_drain_column  = '0;
                    n_drain_byte    = '0;
                end
            endcase
        end
    end

    // payload: held item and output fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_pix <= i_pixel;
            r_eoi <= i_eoi;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_density <= 1'b1;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_column_index <= '0;
            r_rows_filled  <= '0;
            r_draining     <= 1'b0;
            r_phase        <= PH_HEADER;
            r_drain_column <= '0;
            r_drain_byte   <= '0;
            r_final_band   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HIGH_DENSITY: r_high_density <= i_cfg_data[0];
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_column_index <= n_column_index;
                r_rows_filled  <= n_rows_filled;
                r_draining     <= n_draining;
                r_phase        <= n_phase;
                r_drain_column <= n_drain_column;
                r_drain_byte   <= n_drain_byte;
                r_final_band   <= n_final_band;
                r_out_valid    <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_full = r_out_valid;
    assign o_result          = r_out;

endmodule

// ===== src/bit_image_band_encoder.sv =====
// Top level of the column bit-image band encoder.
// Depends on bibe_pkg, bibe_ctrl, bibe_dp (and bibe_ram below it).
`timescale 1ns / 1ps

// Column bit-image band encoder.
// Slave stream: one item per pixel write or drain tick. tuser[0] selects the
// operation (0 pixel write, 1 tick), tdata[0] is the pixel, tlast flags the
// last pixel of the image. Pixels arrive row-major and fill a band of 8 rows
// (normal) or MAX_BAND_ROWS rows (high density) in the band store RAM.
// Master stream: exactly one result item per input item. tdata is the output
// byte, tlast marks the newline closing a band, tuser carries the flags.
// A full band (or an end flag on a last-column pixel) switches to draining:
// each tick then yields mode byte, width low/high, column bytes top row in
// the MSB, and finally 0x0A. Pixels sent while draining come back refused.
// Config port: write index 0 high_density, index 1 image_width; other indexes
// are ignored. Always ready; write only while no item is in flight.
// Timing: an item is taken in the idle state and executed in the execute state (one band
// store access each, read then read-modify-write), so a new item is taken only after the
// last one has executed; its result is loaded into the output register as it executes. While the
// receiver stalls one result waits in the output register and one more item
// may be taken; execution of that item then waits for the register to free.
// Reset clears all counters, sets 24-dot mode and width 576. The band store
// is not cleared; each band starts its column words afresh.
module bit_image_band_encoder
    import bibe_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_BAND_ROWS = DEF_MAX_BAND_ROWS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input items
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [0] pixel, [7:1] zero
    input  logic                    s_axis_tlast,   // end_of_image
    input  logic [0:0]              s_axis_tuser,   // [0] operation
    // result items
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [7:0] data_byte
    output logic                    m_axis_tlast,   // band_end
    output logic [3:0]              m_axis_tuser,   // [0] accepted, [1] misplaced_end,
                                                    // [2] byte_valid, [3] image_end
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [IMG_W_BITS-1:0]   i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    t_result result;

    bibe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (status),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    bibe_dp #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_BAND_ROWS (MAX_BAND_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (s_axis_tuser[0]),
        .i_pixel     (s_axis_tdata[0]),
        .i_eoi       (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_ready   (m_axis_tready),
        .o_result    (result)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = status.out_full;
    assign m_axis_tdata  = result.data_byte;
    assign m_axis_tlast  = result.band_end;
    assign m_axis_tuser  = {result.image_end, result.byte_valid,
                            result.misplaced_end, result.accepted};

    // one item in flight: no second item straight after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is still executing");

    // a band closes only with a newline byte produced by a tick
    a_band_end_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser[2] && !m_axis_tuser[0] && m_axis_tdata == NEWLINE_BYTE))
        else $error("band end on something other than a newline byte");

    // image end is always on a band end
    a_image_end_on_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |-> m_axis_tlast)
        else $error("image end without band end");

    // a misplaced end flag only comes with a stored pixel
    a_misplaced_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && !m_axis_tuser[2]))
        else $error("misplaced end flag on a refused write or a tick");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bit_image_band_encoder: directed and random pixel and tick items,
// each result checked against an in-bench prediction of the band byte stream.
// Depends on bibe_pkg and the encoder RTL only.
module tb_top;
    import bibe_pkg::*;

    localparam int MAX_W    = DEF_MAX_WIDTH;
    localparam int MAX_ROWS = DEF_MAX_BAND_ROWS;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;
    // index with no register behind it; writes to it are dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 5000;  // cycles without any handshake

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = '0;
    logic                    s_axis_tlast = 1'b0;
    logic [0:0]              s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [7:0]              m_axis_tdata;
    logic                    m_axis_tlast;
    logic [3:0]              m_axis_tuser;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [IMG_W_BITS-1:0]   i_cfg_data = '0;

    bit_image_band_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    int err_count    = 0;
    int useful_items = 0;   // stored pixels and byte-producing ticks
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold      = 0;   // forced receiver hold-off, in cycles

    t_result expected_results[$];

    // ---- band encoder prediction ----
    logic                 dense_mode;
    logic [IMG_W_BITS-1:0] row_width;
    logic [WORD_BITS-1:0] column_words [0:MAX_W-1];
    int unsigned          fill_col;
    int unsigned          fill_rows;
    logic                 draining;
    logic [1:0]           drain_ph;
    int unsigned          drain_col;
    int unsigned          drain_sub;
    logic                 last_band;

    function automatic void reset_encoder_state();
        dense_mode = 1'b1;
        row_width  = RST_IMAGE_WIDTH;
        fill_col   = 0;
        fill_rows  = 0;
        draining   = 1'b0;
        drain_ph   = PH_HEADER;
        drain_col  = 0;
        drain_sub  = 0;
        last_band  = 1'b0;
    endfunction

    // width 0 behaves as 1, anything above the store as the store size
    function automatic int unsigned active_width();
        int unsigned w;
        w = int'(row_width);
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic t_result encode_item(input logic op, input logic pix, input logic eoi);
        t_result              r;
        int unsigned          w;
        int unsigned          band_rows;
        int unsigned          col_bytes;
        logic [15:0]          w16;
        logic [WORD_BITS-1:0] word;
        logic                 at_last;
        r         = '0;
        w         = active_width();
        w16       = 16'(w);
        band_rows = dense_mode ? MAX_ROWS : int'(NORMAL_ROWS);
        col_bytes = dense_mode ? (MAX_ROWS + 7) / 8 : 1;
        if (op == OP_PIXEL) begin
            if (!draining) begin
                r.accepted = 1'b1;
                // first row of a band starts the column word afresh
                word = (fill_rows == 0) ? '0 : column_words[fill_col];
                if (pix) word[WORD_BITS-1-fill_rows] = 1'b1;
                column_words[fill_col] = word;
                at_last = (fill_col + 1 >= w);
                if (eoi && !at_last) r.misplaced_end = 1'b1;
                if (!at_last) begin
                    fill_col++;
                end else begin
                    fill_col = 0;
                    fill_rows++;
                    if (fill_rows >= band_rows || eoi) begin
                        fill_rows = 0;
                        draining  = 1'b1;
                        last_band = eoi;
                        drain_ph  = PH_HEADER;
                        drain_col = 0;
                        drain_sub = 0;
                    end
                end
            end
        end else if (draining) begin
            r.byte_valid = 1'b1;
            case (drain_ph)
                PH_HEADER: begin
                    case (drain_sub)
                        0:       r.data_byte = dense_mode ? MODE_HIGH : MODE_NORMAL;
                        1:       r.data_byte = w16[7:0];
                        default: r.data_byte = w16[15:8];
                    endcase
                    if (drain_sub >= 2) begin
                        drain_sub = 0;
                        drain_col = 0;
                        drain_ph  = PH_DATA;
                    end else begin
                        drain_sub++;
                    end
                end
                PH_DATA: begin
                    // top row sits in the MSB of the first byte
                    word        = column_words[drain_col];
                    r.data_byte = word[WORD_BITS-1-8*drain_sub -: 8];
                    drain_sub++;
                    if (drain_sub >= col_bytes) begin
                        drain_sub = 0;
                        drain_col++;
                        if (drain_col >= w) drain_ph = PH_NEWLINE;
                    end
                end
                default: begin
                    r.data_byte = NEWLINE_BYTE;
                    r.band_end  = 1'b1;
                    r.image_end = last_band;
                    draining    = 1'b0;
                    last_band   = 1'b0;
                    drain_ph    = PH_HEADER;
                    drain_col   = 0;
                    drain_sub   = 0;
                end
            endcase
        end
        return r;
    endfunction

    // ---- result checking ----
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("accepted", int'(want.accepted), int'(m_axis_tuser[0]));
                check_field("misplaced_end", int'(want.misplaced_end), int'(m_axis_tuser[1]));
                check_field("byte_valid", int'(want.byte_valid), int'(m_axis_tuser[2]));
                check_field("data_byte", int'(want.data_byte), int'(m_axis_tdata));
                check_field("band_end", int'(want.band_end), int'(m_axis_tlast));
                check_field("image_end", int'(want.image_end), int'(m_axis_tuser[3]));
            end
        end
    end

    // receiver: forced hold-off first, otherwise random stalls
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no handshake anywhere
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---- drivers ----
    // valid stays high on return so back-to-back items need no re-raise
    task automatic send_item(input logic op, input logic pix, input logic eoi);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pix};
        s_axis_tlast  <= eoi;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = encode_item(op, pix, eoi);
        if (r.accepted || r.byte_valid) useful_items++;
        expected_results.push_back(r);
    endtask

    task automatic wait_stream_empty();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [IMG_W_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HIGH_DENSITY: dense_mode = value[0];
            CFG_IMAGE_WIDTH:  row_width  = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // density bit with junk in the upper data bits, then the width
    task automatic set_mode(input logic dens, input logic [IMG_W_BITS-1:0] width);
        write_reg(CFG_HIGH_DENSITY, {10'($urandom), dens});
        write_reg(CFG_IMAGE_WIDTH, width);
    endtask

    // tick until the band is out; refuse_pct mixes in pixels that must bounce
    task automatic drain_band(input int refuse_pct);
        while (draining) begin
            if ($urandom_range(0, 99) < refuse_pct)
                send_item(OP_PIXEL, 1'($urandom), 1'($urandom));
            else
                send_item(OP_TICK, 1'($urandom), 1'($urandom));
        end
    endtask

    // ---- tests ----
    task automatic test_directed();
        send_item(OP_TICK, 1'b1, 1'b1);           // idle tick, no byte
        wait_stream_empty();
        write_reg(CFG_SPARE, '1);                 // dropped
        set_mode(1'b0, 11'd0);                    // width 0 runs as 1
        send_item(OP_PIXEL, 1'b1, 1'b1);          // one-pixel image
        send_item(OP_PIXEL, 1'b1, 1'b1);          // refused while draining
        repeat (5) send_item(OP_TICK, 1'b0, 1'b0);
        wait_stream_empty();
        set_mode(1'b1, 11'd2);
        send_item(OP_PIXEL, 1'b1, 1'b1);          // end flag off the last column
        send_item(OP_PIXEL, 1'b1, 1'b1);
        drain_band(0);
    endtask

    // narrower width and 8-row mode switched in part way through a 24-row band
    task automatic test_mid_band_config();
        wait_stream_empty();
        set_mode(1'b1, 11'd4);
        repeat (11) send_item(OP_PIXEL, 1'($urandom), 1'b0);
        wait_stream_empty();
        set_mode(1'b0, 11'd2);
        // first pixel sits past the new last column and closes its row
        repeat (11) send_item(OP_PIXEL, 1'($urandom), 1'b0);
        drain_band(0);
    endtask

    // width bytes at the full store width and above it: the wide setting is
    // held only for the header of a narrow band, then the narrow width returns
    task automatic test_wide_rows();
        logic [IMG_W_BITS-1:0] widths [2];
        widths[0] = IMG_W_BITS'(MAX_W);
        widths[1] = '1;
        foreach (widths[k]) begin
            wait_stream_empty();
            set_mode(1'b0, 11'd2);
            send_item(OP_PIXEL, 1'($urandom), 1'b0);
            send_item(OP_PIXEL, 1'($urandom), 1'b1);
            wait_stream_empty();
            write_reg(CFG_IMAGE_WIDTH, widths[k]);
            repeat (3) send_item(OP_TICK, 1'b0, 1'b0);   // mode, width low, width high
            wait_stream_empty();
            write_reg(CFG_IMAGE_WIDTH, 11'd2);
            drain_band(0);
        end
    endtask

    // receiver held off while a full band without end flag comes in, then a one-row image with end flag
    task automatic test_backpressure();
        wait_stream_empty();
        set_mode(1'b0, 11'd16);
        rx_hold = 300;
        repeat (16 * 8) send_item(OP_PIXEL, 1'($urandom), 1'b0);
        drain_band(0);
        wait_stream_empty();                      // sender waits for every result
        repeat (15) send_item(OP_PIXEL, 1'($urandom), 1'b0);
        send_item(OP_PIXEL, 1'($urandom), 1'b1);
        drain_band(0);
    endtask

    task automatic random_image();
        int unsigned sel;
        int unsigned width;
        int unsigned w_eff;
        int unsigned rows;
        int unsigned band_rows;
        logic        dens;
        logic        eoi;
        wait_stream_empty();
        dens = 1'($urandom);
        sel  = $urandom_range(0, 99);
        if (sel < 4)       width = 0;
        else if (sel < 85) width = $urandom_range(1, 12);
        else               width = $urandom_range(13, 48);
        set_mode(dens, IMG_W_BITS'(width));
        w_eff     = active_width();
        band_rows = dens ? MAX_ROWS : int'(NORMAL_ROWS);
        if (w_eff > 16) rows = $urandom_range(1, 3);
        else            rows = $urandom_range(1, band_rows + 4);
        if (rows * w_eff > 160) rows = 160 / w_eff;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < w_eff; c++) begin
                drain_band(8);                    // band filled before the image ended
                if ($urandom_range(0, 99) < 3) send_item(OP_TICK, 1'($urandom), 1'($urandom));
                eoi = (r == rows - 1 && c == w_eff - 1) ||
                      (c != w_eff - 1 && $urandom_range(0, 99) < 3);
                send_item(OP_PIXEL, 1'($urandom), eoi);
            end
        end
        drain_band(8);
        if ($urandom_range(0, 3) == 0) send_item(OP_TICK, 1'($urandom), 1'($urandom));
    endtask

    task automatic test_random_images(input int idle_pct, input int stall_pct, input int quota);
        int start;
        wait_stream_empty();
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        start        = useful_items;
        while (useful_items - start < quota) random_image();
    endtask

    initial begin
        reset_encoder_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_mid_band_config();
        test_wide_rows();
        test_backpressure();
        test_random_images(0, 0, 90);
        test_random_images(80, 0, 90);
        test_random_images(0, 80, 90);
        test_random_images(37, 37, 90);

        wait_stream_empty();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/bibe_pkg.sv
src/bibe_ram.sv
src/bibe_ctrl.sv
src/bibe_dp.sv
src/bit_image_band_encoder.sv
bench/tb_top.sv
